[hdl/tdpc_pkg.sv]
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared types, widths and verdict codes of the two-dimensional parity checker
// ----------------------------------------------------------------------------
package tdpc_pkg;

    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = $clog2(MAX_SIZE + 1);
    localparam int CFG_W    = 7;
    localparam int POS_W    = 7;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_FIX     = 2'd1;
    localparam logic [1:0] VERDICT_CORRUPT = 2'd2;

    // summary of one finished matrix, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]    odd_rows;
        logic [POS_W-1:0]    last_row;
        logic [CNT_W-1:0]    odd_cols;
        logic [MAX_SIZE-1:0] col_par;
    } tdpc_summary_t;

endpackage

[hdl/two_dim_parity_checker_top.sv]
// ----------------------------------------------------------------------------
// two_dim_parity_checker_top
// two-dimensional even parity check of a square bit matrix, one bit per item
// ----------------------------------------------------------------------------
// throughput: one bit per cycle, sustained; the front accumulator takes a bit
//   every cycle while the two-entry summary queue is not full
// path: the summary of a matrix passes the queue, then the result register, before
//   its verdict is on the result ports
// reset: asynchronous, active low; matrix size back to 8, all parity state
//   cleared, queue emptied and result register marked empty, no clearing pass
// ----------------------------------------------------------------------------
module two_dim_parity_checker_top
    import tdpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration: matrix size, to be taken when idle; the block does not check
    input  logic              matrix_size_we,
    input  logic [CFG_W-1:0]  matrix_size,

    // bit stream in, queue style
    input  logic              push,
    output logic              full,
    input  logic              data_bit,

    // verdicts out, queue style
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        verdict,
    output logic [POS_W-1:0]  bad_row,
    output logic [POS_W-1:0]  bad_col
);

    logic           in_valid;
    logic           sum_push;
    tdpc_summary_t  sum_data;
    logic           q_full;
    logic           q_valid;
    tdpc_summary_t  q_head;
    logic           q_pop;

    // input transaction: push while the queue has room; the full flag is the
    // queue's own full flag, so a bit ending a matrix always finds a free slot
    assign full     = q_full;
    assign in_valid = push && !q_full;

    // front: running row parity, column parity vector and odd counts
    tdpc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .matrix_size_we (matrix_size_we),
        .matrix_size    (matrix_size),
        .in_valid       (in_valid),
        .data_bit       (data_bit),
        .sum_push       (sum_push),
        .sum_data       (sum_data)
    );

    // decoupling queue of per-matrix summaries
    tdpc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (sum_push),
        .push_data  (sum_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // back: verdict decision, odd column position, result register
    tdpc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_data  (q_head),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .verdict    (verdict),
        .bad_row    (bad_row),
        .bad_col    (bad_col)
    );

endmodule

[hdl/tdpc_front.sv]
// ----------------------------------------------------------------------------
// tdpc_front
// accumulates row and column parities and emits a summary per matrix
// ----------------------------------------------------------------------------
module tdpc_front
    import tdpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                matrix_size_we,
    input  logic [CFG_W-1:0]    matrix_size,
    input  logic                in_valid,
    input  logic                data_bit,
    output logic                sum_push,
    output tdpc_summary_t       sum_data
);

    logic [CFG_W-1:0]    size_reg,     size_next;
    logic [IDX_W-1:0]    row_idx_reg,  row_idx_next;
    logic [IDX_W-1:0]    col_idx_reg,  col_idx_next;
    logic                row_par_reg,  row_par_next;
    logic [MAX_SIZE-1:0] col_par_reg,  col_par_next;
    logic [CNT_W-1:0]    odd_rows_reg, odd_rows_next;
    logic [POS_W-1:0]    last_row_reg, last_row_next;
    logic [CNT_W-1:0]    odd_cols_reg, odd_cols_next;

    logic [IDX_W-1:0]    last_idx;
    logic [CFG_W-1:0]    size_m1;
    logic [MAX_SIZE-1:0] col_par_upd;
    logic [CNT_W-1:0]    odd_cols_upd;
    logic [CNT_W-1:0]    odd_rows_upd;
    logic [POS_W-1:0]    last_row_upd;
    logic                row_par_upd;
    logic                row_end;
    logic                mat_end;

    // clamp the size register into 1..MAX_SIZE, as last index
    always_comb
    begin
        size_m1 = size_reg - 1'b1;
        if (size_reg == '0)
            last_idx = '0;
        else if (size_reg > CFG_W'(MAX_SIZE))
            last_idx = IDX_W'(MAX_SIZE - 1);
        else
            last_idx = size_m1[IDX_W-1:0];
    end

    always_comb
    begin
        col_par_upd  = col_par_reg ^ ({{(MAX_SIZE-1){1'b0}}, data_bit} << col_idx_reg);
        odd_cols_upd = odd_cols_reg;
        if (data_bit)
        begin
            if (col_par_reg[col_idx_reg])
                odd_cols_upd = odd_cols_reg - 1'b1;
            else
                odd_cols_upd = odd_cols_reg + 1'b1;
        end
        row_par_upd  = row_par_reg ^ data_bit;
        odd_rows_upd = odd_rows_reg + CNT_W'(row_par_upd);
        last_row_upd = row_par_upd ? (POS_W'(row_idx_reg) + 1'b1) : last_row_reg;
        row_end      = (col_idx_reg == last_idx);
        mat_end      = row_end && (row_idx_reg == last_idx);
    end

    always_comb
    begin
        size_next     = size_reg;
        row_idx_next  = row_idx_reg;
        col_idx_next  = col_idx_reg;
        row_par_next  = row_par_reg;
        col_par_next  = col_par_reg;
        odd_rows_next = odd_rows_reg;
        last_row_next = last_row_reg;
        odd_cols_next = odd_cols_reg;
        if (matrix_size_we)
        begin
            size_next     = matrix_size;
            row_idx_next  = '0;
            col_idx_next  = '0;
            row_par_next  = 1'b0;
            col_par_next  = '0;
            odd_rows_next = '0;
            last_row_next = '0;
            odd_cols_next = '0;
        end
        else if (in_valid)
        begin
            if (mat_end)
            begin
                row_idx_next  = '0;
                col_idx_next  = '0;
                row_par_next  = 1'b0;
                col_par_next  = '0;
                odd_rows_next = '0;
                last_row_next = '0;
                odd_cols_next = '0;
            end
            else if (row_end)
            begin
                row_idx_next  = row_idx_reg + 1'b1;
                col_idx_next  = '0;
                row_par_next  = 1'b0;
                col_par_next  = col_par_upd;
                odd_rows_next = odd_rows_upd;
                last_row_next = last_row_upd;
                odd_cols_next = odd_cols_upd;
            end
            else
            begin
                col_idx_next  = col_idx_reg + 1'b1;
                row_par_next  = row_par_upd;
                col_par_next  = col_par_upd;
                odd_cols_next = odd_cols_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_RESET;
            row_idx_reg  <= '0;
            col_idx_reg  <= '0;
            row_par_reg  <= 1'b0;
            col_par_reg  <= '0;
            odd_rows_reg <= '0;
            last_row_reg <= '0;
            odd_cols_reg <= '0;
        end
        else
        begin
            size_reg     <= size_next;
            row_idx_reg  <= row_idx_next;
            col_idx_reg  <= col_idx_next;
            row_par_reg  <= row_par_next;
            col_par_reg  <= col_par_next;
            odd_rows_reg <= odd_rows_next;
            last_row_reg <= last_row_next;
            odd_cols_reg <= odd_cols_next;
        end
    end

    assign sum_push          = in_valid && mat_end && !matrix_size_we;
    assign sum_data.odd_rows = odd_rows_upd;
    assign sum_data.last_row = last_row_upd;
    assign sum_data.odd_cols = odd_cols_upd;
    assign sum_data.col_par  = col_par_upd;

    // running odd column count tracks the parity vector
    a_odd_cols_match: assert property (@(posedge clk) disable iff (!rst_n)
        odd_cols_reg == CNT_W'($countones(col_par_reg)))
        else $error("odd column count out of step with column parities");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_idx_reg <= last_idx || $past(matrix_size_we))
        else $error("column index beyond matrix size");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        sum_push |=> (col_idx_reg == '0 && row_idx_reg == '0 && col_par_reg == '0))
        else $error("accumulation not cleared after matrix end");

endmodule

[hdl/tdpc_queue.sv]
// ----------------------------------------------------------------------------
// tdpc_queue
// short queue of matrix summaries between front and back
// ----------------------------------------------------------------------------
module tdpc_queue
    import tdpc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tdpc_summary_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tdpc_summary_t  head_data
);

    tdpc_summary_t      entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("summary queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("summary queue underflow");

endmodule

[hdl/tdpc_back.sv]
// ----------------------------------------------------------------------------
// tdpc_back
// turns a matrix summary into a verdict and holds it in the result register
// ----------------------------------------------------------------------------
module tdpc_back
    import tdpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tdpc_summary_t     head_data,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output logic [1:0]        verdict,
    output logic [POS_W-1:0]  bad_row,
    output logic [POS_W-1:0]  bad_col
);

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        verdict_reg;
    logic [POS_W-1:0]  bad_row_reg;
    logic [POS_W-1:0]  bad_col_reg;

    logic [IDX_W-1:0]  pos;
    logic [1:0]        v_new;
    logic [POS_W-1:0]  r_new;
    logic [POS_W-1:0]  c_new;
    logic              load;

    // with exactly one odd column, its index is the or of all set indexes
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < MAX_SIZE; k++)
        begin
            if (head_data.col_par[k])
                pos = pos | IDX_W'(k);
        end
    end

    always_comb
    begin
        v_new = VERDICT_CORRUPT;
        r_new = '0;
        c_new = '0;
        if (head_data.odd_rows == '0 && head_data.odd_cols == '0)
            v_new = VERDICT_OK;
        else if (head_data.odd_rows == CNT_W'(1) && head_data.odd_cols == CNT_W'(1))
        begin
            v_new = VERDICT_FIX;
            r_new = head_data.last_row;
            c_new = POS_W'(pos) + 1'b1;
        end
    end

    assign load     = head_valid && (!out_valid_reg || pop);
    assign head_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= v_new;
            bad_row_reg <= r_new;
            bad_col_reg <= c_new;
        end
    end

    assign empty   = !out_valid_reg;
    assign verdict = verdict_reg;
    assign bad_row = bad_row_reg;
    assign bad_col = bad_col_reg;

    a_pos_zero_unless_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg != VERDICT_FIX) |-> (bad_row_reg == '0 && bad_col_reg == '0))
        else $error("position reported without a correctable verdict");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("result register not filled after load");

endmodule
